/* hw/rtl/lsrs_pkg.sv */
// ----------------------------------------------------------------------------
// lsrs_pkg
// Shared types and constants of the display link row sniffer: request and
// parser state codes, protocol bytes, frame store geometry and queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsrs_pkg;

  // frame store geometry
  localparam int STORE_DEPTH = 2048;
  localparam int ADDR_W      = 11;
  localparam int QUEUE_DEPTH = 2;

  // request codes
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_CS   = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // parser state codes
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_BETWEEN = 3'd1;
  localparam logic [2:0] ST_ROW     = 3'd2;
  localparam logic [2:0] ST_DATA    = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;
  localparam logic [2:0] ST_ERROR   = 3'd5;

  // protocol bytes
  localparam logic [7:0] CMD_WRITE_LINE = 8'h01;
  localparam logic [7:0] TRAILER_BYTE   = 8'hFF;

  // store operation carried to the back end
  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ
  } op_e;

  // one queued transaction, already classified by the front end
  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    logic [2:0]        parser_state;
    logic [2:0]        error_state;
    logic              byte_error;
  } q_entry_t;

  // reasons for the front end to hold off input
  typedef struct packed {
    logic q_full;
    logic clear_busy;
  } front_hold_t;

endpackage

/* hw/rtl/lsrs_if.sv */
// ----------------------------------------------------------------------------
// lsrs_if
// Valid/ready channels of the row sniffer: request channel and result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lsrs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  spi_byte;
  logic [10:0] read_address;

  modport source (output valid, req_type, spi_byte, read_address, input ready);
  modport sink   (input valid, req_type, spi_byte, read_address, output ready);
endinterface

interface lsrs_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [2:0] parser_state;
  logic [2:0] error_state;
  logic       byte_error;

  modport source (output valid, read_data, parser_state, error_state, byte_error,
                  input ready);
  modport sink   (input valid, read_data, parser_state, error_state, byte_error,
                  output ready);
endinterface

/* hw/rtl/lcd_spi_row_sniffer_top.sv */
// Path: a request waits in the queue, its result in the output register.
// Throughput: one transaction per cycle, set by the single store port in the
// back end and the two-entry queue in front of it, while results are taken.
// Reset: asynchronous, active low; afterwards the frame store is swept to zero,
// one byte a cycle, and no request is taken until all 2048 bytes are cleared.
// ----------------------------------------------------------------------------
// lcd_spi_row_sniffer_top
// Rebuilds the frame store of a line-addressed display from sniffed link bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_spi_row_sniffer_top #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsrs_req_if.sink    in_i,
  lsrs_rsp_if.source  out_o
);
  import lsrs_pkg::*;

  q_entry_t    push_entry, pop_entry;
  logic        push, pop, q_full, q_empty, clear_busy;
  front_hold_t hold;

  assign hold.q_full     = q_full;
  assign hold.clear_busy = clear_busy;

  // parser front end
  lsrs_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (in_i),
    .hold_i  (hold),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // decoupling queue
  lsrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // frame store back end
  lsrs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (pop_entry),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .clear_busy_o (clear_busy),
    .rsp_o        (out_o)
  );

endmodule

/* hw/rtl/lsrs_front.sv */
// ----------------------------------------------------------------------------
// lsrs_front
// Protocol parser: accepts request transactions, runs the line protocol state
// machine and turns each transaction into a classified queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsrs_front #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lsrs_req_if.sink             req_i,
  input  lsrs_pkg::front_hold_t hold_i,
  output logic                 push_o,
  output lsrs_pkg::q_entry_t   entry_o
);
  import lsrs_pkg::*;

  localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
  localparam int CNT_W     = $clog2(ROW_BYTES + 1);

  logic [2:0]        parse_q, parse_d;
  logic [2:0]        last_err_q, last_err_d;
  logic [ADDR_W-1:0] waddr_q, waddr_d;
  logic [CNT_W-1:0]  col_q, col_d;
  logic [CNT_W-1:0]  col_inc;
  logic [7:0]        row_m1;
  logic [31:0]       row_base;
  logic              accept;

  // handshake
  assign req_i.ready = !hold_i.q_full && !hold_i.clear_busy;
  assign accept      = req_i.valid && req_i.ready;
  assign push_o      = accept;

  // row start address, row number is one based
  assign row_m1   = req_i.spi_byte - 8'd1;
  assign row_base = 32'(row_m1) * 32'(ROW_BYTES);
  assign col_inc  = col_q + CNT_W'(1);

  // next state and entry classification
  always_comb begin
    parse_d               = parse_q;
    last_err_d            = last_err_q;
    waddr_d               = waddr_q;
    col_d                 = col_q;
    entry_o.op            = OP_NONE;
    entry_o.addr          = waddr_q;
    entry_o.wdata         = req_i.spi_byte;
    entry_o.byte_error    = 1'b0;
    case (req_i.req_type)
      REQ_BYTE: begin
        case (parse_q)
          ST_IDLE: begin
            if (req_i.spi_byte == CMD_WRITE_LINE) begin
              parse_d = ST_ROW;
            end else begin
              last_err_d         = parse_q;
              parse_d            = ST_ERROR;
              entry_o.byte_error = 1'b1;
            end
          end
          ST_ROW: begin
            if (req_i.spi_byte == TRAILER_BYTE) begin
              parse_d = ST_DONE;
            end else if (req_i.spi_byte == 8'd0 ||
                         req_i.spi_byte > 8'(SCREEN_HEIGHT)) begin
              last_err_d         = parse_q;
              parse_d            = ST_ERROR;
              entry_o.byte_error = 1'b1;
            end else begin
              waddr_d = row_base[ADDR_W-1:0];
              col_d   = '0;
              parse_d = ST_DATA;
            end
          end
          ST_DATA: begin
            entry_o.op = OP_WRITE;
            waddr_d    = waddr_q + ADDR_W'(1);
            col_d      = col_inc;
            if (col_inc >= CNT_W'(ROW_BYTES)) begin
              parse_d = ST_BETWEEN;
            end
          end
          ST_BETWEEN: begin
            if (req_i.spi_byte == TRAILER_BYTE) begin
              parse_d = ST_ROW;
            end else begin
              last_err_d         = parse_q;
              parse_d            = ST_ERROR;
              entry_o.byte_error = 1'b1;
            end
          end
          default: begin
            // done and error ignore bytes
          end
        endcase
      end
      REQ_CS: begin
        parse_d = ST_IDLE;
      end
      REQ_READ: begin
        entry_o.op   = OP_READ;
        entry_o.addr = req_i.read_address;
      end
      default: begin
        // unused request code changes nothing
      end
    endcase
    entry_o.parser_state = parse_d;
    entry_o.error_state  = last_err_d;
  end

  // parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q    <= ST_IDLE;
      last_err_q <= 3'd0;
      waddr_q    <= '0;
      col_q      <= '0;
    end else if (accept) begin
      parse_q    <= parse_d;
      last_err_q <= last_err_d;
      waddr_q    <= waddr_d;
      col_q      <= col_d;
    end
  end

endmodule

/* hw/rtl/lsrs_queue.sv */
// ----------------------------------------------------------------------------
// lsrs_queue
// Two-entry queue decoupling the protocol parser from the frame store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsrs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lsrs_pkg::q_entry_t entry_i,
  input  logic               pop_i,
  output lsrs_pkg::q_entry_t entry_o,
  output logic               full_o,
  output logic               empty_o
);
  import lsrs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  q_entry_t         slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PTR_W+1)'(1);
      end
    end
  end

endmodule

/* hw/rtl/lsrs_back.sv */
// ----------------------------------------------------------------------------
// lsrs_back
// Frame store executor: clears the store after reset, then carries out queued
// writes and reads in order and holds each result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsrs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsrs_pkg::q_entry_t entry_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               clear_busy_o,
  lsrs_rsp_if.source         rsp_o
);
  import lsrs_pkg::*;

  logic [7:0]        store_q [STORE_DEPTH];
  logic [7:0]        rdata_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic              clr_busy_q;
  logic              out_valid_q;
  logic              is_read_q;
  logic [2:0]        pstate_q;
  logic [2:0]        estate_q;
  logic              berr_q;

  assign clear_busy_o = clr_busy_q;
  assign pop_o        = !empty_i && !clr_busy_q && (!out_valid_q || rsp_o.ready);

  // frame store, clearing pass has the write port first
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      store_q[clr_addr_q] <= 8'd0;
    end else if (pop_o && entry_i.op == OP_WRITE) begin
      store_q[entry_i.addr] <= entry_i.wdata;
    end
    if (pop_o) begin
      rdata_q <= store_q[entry_i.addr];
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      is_read_q <= (entry_i.op == OP_READ);
      pstate_q  <= entry_i.parser_state;
      estate_q  <= entry_i.error_state;
      berr_q    <= entry_i.byte_error;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.read_data    = is_read_q ? rdata_q : 8'd0;
  assign rsp_o.parser_state = pstate_q;
  assign rsp_o.error_state  = estate_q;
  assign rsp_o.byte_error   = berr_q;

endmodule

/* hw/rtl/lsrs_checker.sv */
// ----------------------------------------------------------------------------
// lsrs_checker
// Port-level checks of the row sniffer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] read_data_i,
  input logic [2:0] parser_state_i,
  input logic [2:0] error_state_i,
  input logic       byte_error_i
);
  import lsrs_pkg::*;

  logic [2:0] pending_q;
  logic       in_txn, out_txn;

  assign in_txn  = in_valid_i && in_ready_i;
  assign out_txn = out_valid_i && out_ready_i;

  // transactions taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_txn && !out_txn) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_txn && !in_txn) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  // no result without a request behind it
  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 3'd0)
    else $error("result shown with no outstanding request");

  // queue plus output register bound the requests in flight
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3)
    else $error("more requests in flight than storage allows");

  // a protocol error always leaves the parser in the error state
  a_error_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && byte_error_i) |-> parser_state_i == ST_ERROR)
    else $error("byte error reported outside the error state");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(read_data_i) &&
      $stable(parser_state_i) && $stable(error_state_i) && $stable(byte_error_i))
    else $error("stalled result changed");

endmodule

bind lcd_spi_row_sniffer_top lsrs_checker u_lsrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .read_data_i    (out_o.read_data),
  .parser_state_i (out_o.parser_state),
  .error_state_i  (out_o.error_state),
  .byte_error_i   (out_o.byte_error)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the display link row sniffer. A behavioural mirror
// of the parser and its frame store predicts each result transaction. Stimulus
// is a directed pass over the protocol corners, then random frames with
// broken sequences, noise and read-back, under random stalls on both channels.
// ----------------------------------------------------------------------------

module testbench;
  import lsrs_pkg::*;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 128;
  localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT   = 12000;
  localparam int RANDOM_ITEMS  = 420;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] parser_state;
    logic [2:0] error_state;
    logic       byte_error;
  } rsp_t;

  logic clk;
  logic rst_n;

  lsrs_req_if req_ch ();
  lsrs_rsp_if rsp_ch ();

  lcd_spi_row_sniffer_top #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_ch),
    .out_o (rsp_ch)
  );

  // mirror of the parser state and the frame store
  logic [2:0]  mirror_state;
  logic [2:0]  mirror_err_state;
  logic [10:0] mirror_wr_addr;
  int          mirror_col;
  logic [7:0]  frame_mirror [STORE_DEPTH];

  rsp_t pending_rsp_q [$];
  rsp_t exp_rsp;
  int   fail_count;
  int   sent_items;
  bit   src_idle_en;
  bit   sink_idle_en;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one sniffed byte through the mirrored parser, returns the error flag
  function automatic logic parse_byte(input logic [7:0] b);
    logic err;
    err = 1'b0;
    case (mirror_state)
      ST_IDLE: begin
        if (b == CMD_WRITE_LINE) mirror_state = ST_ROW;
        else err = 1'b1;
      end
      ST_ROW: begin
        if (b == TRAILER_BYTE) begin
          mirror_state = ST_DONE;
        end else if (b == 8'd0 || int'(b) > SCREEN_HEIGHT) begin
          err = 1'b1;
        end else begin
          mirror_wr_addr = 11'((int'(b) - 1) * ROW_BYTES);
          mirror_col     = 0;
          mirror_state   = ST_DATA;
        end
      end
      ST_DATA: begin
        frame_mirror[mirror_wr_addr] = b;
        mirror_wr_addr = mirror_wr_addr + 11'd1;
        mirror_col++;
        if (mirror_col >= ROW_BYTES) mirror_state = ST_BETWEEN;
      end
      ST_BETWEEN: begin
        if (b == TRAILER_BYTE) mirror_state = ST_ROW;
        else err = 1'b1;
      end
      default: ;
    endcase
    // done and error swallow bytes, otherwise a bad byte is recorded
    if (err) begin
      mirror_err_state = mirror_state;
      mirror_state     = ST_ERROR;
    end
    return err;
  endfunction

  // expected result of one request transaction
  function automatic rsp_t sniff_step(input logic [1:0] kind, input logic [7:0] b,
                                      input logic [10:0] addr);
    rsp_t r;
    r = '0;
    case (kind)
      REQ_BYTE: r.byte_error = parse_byte(b);
      REQ_CS:   mirror_state = ST_IDLE;
      REQ_READ: r.read_data = frame_mirror[addr];
      default: ;
    endcase
    r.parser_state = mirror_state;
    r.error_state  = mirror_err_state;
    return r;
  endfunction

  // drive one request and wait for its handshake
  task automatic send_item(input logic [1:0] kind, input logic [7:0] b,
                           input logic [10:0] addr);
    int gap;
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.spi_byte     <= b;
    req_ch.read_address <= addr;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp_q.push_back(sniff_step(kind, b, addr));
    sent_items++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(REQ_BYTE, b, 11'($urandom));
  endtask

  task automatic send_cs();
    send_item(REQ_CS, 8'($urandom), 11'($urandom));
  endtask

  task automatic send_read(input logic [10:0] addr);
    send_item(REQ_READ, 8'($urandom), addr);
  endtask

  // hold the request side until every outstanding result is back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp_q.size() != 0);
  endtask

  // one frame, mostly well formed, sometimes broken
  task automatic send_frame();
    int rows;
    int row;
    int n_data;
    send_cs();
    send_byte(($urandom_range(0, 19) == 0) ? 8'($urandom) : CMD_WRITE_LINE);
    rows = $urandom_range(1, 3);
    for (int r = 0; r < rows; r++) begin
      case ($urandom_range(0, 11))
        0:       row = 0;
        1:       row = $urandom_range(SCREEN_HEIGHT + 1, 254);
        2:       row = 255;
        3:       row = 1;
        4:       row = SCREEN_HEIGHT;
        default: row = $urandom_range(1, SCREEN_HEIGHT);
      endcase
      send_byte(8'(row));
      // occasionally cut the row short and let the next chip select recover
      if ($urandom_range(0, 24) == 0) begin
        n_data = $urandom_range(0, ROW_BYTES - 1);
        repeat (n_data) send_byte(8'($urandom));
        return;
      end
      repeat (ROW_BYTES) send_byte(8'($urandom));
      send_byte(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 254)) : TRAILER_BYTE);
      // read back part of the row just written
      if (row >= 1 && row <= SCREEN_HEIGHT) begin
        repeat (2) send_read(11'((row - 1) * ROW_BYTES + $urandom_range(0, ROW_BYTES - 1)));
      end
    end
    send_byte(TRAILER_BYTE);
  endtask

  // protocol corners: idle, row bounds, early end, ignored bytes, unused type
  task automatic test_directed_protocol();
    send_read(11'd0);
    send_read(11'h7FF);
    send_byte(8'h55);
    send_byte(CMD_WRITE_LINE);
    send_item(REQ_UNUSED, 8'hFF, 11'h7FF);
    send_cs();
    send_byte(CMD_WRITE_LINE);
    send_byte(8'h00);
    send_cs();
    send_byte(CMD_WRITE_LINE);
    send_byte(8'(SCREEN_HEIGHT + 1));
    send_cs();
    send_byte(CMD_WRITE_LINE);
    send_byte(8'hFE);
    send_cs();
    send_byte(CMD_WRITE_LINE);
    send_byte(TRAILER_BYTE);
    send_byte(CMD_WRITE_LINE);
  endtask

  // bottom row written with extreme data, then the frame closed and read back
  task automatic test_directed_row_write();
    send_cs();
    send_byte(CMD_WRITE_LINE);
    send_byte(8'(SCREEN_HEIGHT));
    send_byte(8'h00);
    for (int i = 1; i < ROW_BYTES - 1; i++) send_byte((i % 2) ? 8'hAA : 8'h55);
    send_byte(8'hFF);
    send_byte(TRAILER_BYTE);
    send_byte(TRAILER_BYTE);
    send_read(11'h7FF);
    send_read(11'((SCREEN_HEIGHT - 1) * ROW_BYTES));
  endtask

  // sender stops mid frame until the queue has emptied
  task automatic test_pressure_pause();
    send_cs();
    send_byte(CMD_WRITE_LINE);
    send_byte(8'($urandom_range(1, SCREEN_HEIGHT)));
    repeat (ROW_BYTES / 2) send_byte(8'($urandom));
    drain_results();
    repeat (ROW_BYTES - ROW_BYTES / 2) send_byte(8'($urandom));
    send_byte(TRAILER_BYTE);
    send_byte(TRAILER_BYTE);
  endtask

  // random frames, reads and noise with idling switched per stretch
  task automatic test_random_traffic();
    int target;
    target = sent_items + RANDOM_ITEMS;
    while (sent_items < target) begin
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) send_item(2'($urandom), 8'($urandom), 11'($urandom));
        1: send_read(11'($urandom));
        default: send_frame();
      endcase
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_unthrottled_tail();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (2) send_frame();
    repeat (4) send_read(11'($urandom));
  endtask

  task automatic check_field(input string name, input logic [7:0] expected,
                             input logic [7:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0h, got %0h", name, expected, actual);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp_q.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_count++;
      end else begin
        exp_rsp = pending_rsp_q.pop_front();
        check_field("read_data", exp_rsp.read_data, rsp_ch.read_data);
        check_field("parser_state", 8'(exp_rsp.parser_state), 8'(rsp_ch.parser_state));
        check_field("error_state", 8'(exp_rsp.error_state), 8'(rsp_ch.error_state));
        check_field("byte_error", 8'(exp_rsp.byte_error), 8'(rsp_ch.byte_error));
      end
    end
  end

  // result side back-pressure
  initial begin : sink_ready
    int stall;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_idle_en && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(1, 18);
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[lcd_spi_row_sniffer_top] ERROR");
    $finish;
  end

  // reset and test sequence
  initial begin
    rst_n               <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_BYTE;
    req_ch.spi_byte     <= 8'h00;
    req_ch.read_address <= 11'd0;
    mirror_state     = ST_IDLE;
    mirror_err_state = ST_IDLE;
    mirror_wr_addr   = 11'd0;
    mirror_col       = 0;
    foreach (frame_mirror[i]) frame_mirror[i] = 8'h00;
    fail_count   = 0;
    sent_items   = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_protocol();
    test_directed_row_write();
    test_pressure_pause();
    test_random_traffic();
    test_unthrottled_tail();

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_rsp_q.size() == 0) begin
      $display("[lcd_spi_row_sniffer_top] OK");
    end else begin
      $display("[lcd_spi_row_sniffer_top] ERROR");
    end
    $finish;
  end

endmodule
